### src/wsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types and constants for the byte-serial frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int unsigned MaxPayloadW = 23;
  localparam logic [MaxPayloadW-1:0] MaxPayloadReset = 23'h400000;

  localparam logic [7:0] Len7Ext16 = 8'd126;
  localparam logic [7:0] Len7Ext64 = 8'd127;
  localparam logic [6:0] CtrlMaxLen = 7'd125;

  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  typedef enum logic [1:0] {
    RT_TEXT  = 2'd0,
    RT_PONG  = 2'd1,
    RT_CLOSE = 2'd2,
    RT_NONE  = 2'd3
  } route_e;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_CLOSE    = 3'd1,
    CAUSE_OVERSIZE = 3'd2,
    CAUSE_UNMASKED = 3'd3,
    CAUSE_NONFINAL = 3'd4
  } cause_e;

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_EXT  = 6'b000100,
    PH_KEY  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DEAD = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    route_e     route;
    logic       last_of_frame;
    logic       empty_frame;
    logic       link_drop;
    cause_e     drop_cause;
  } wsfd_result_t;

endpackage

### src/wsfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer channels
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] route;
  logic       last_of_frame;
  logic       empty_frame;
  logic       link_drop;
  logic [2:0] drop_cause;

  modport source (output valid, output data_byte, output route, output last_of_frame,
                  output empty_frame, output link_drop, output drop_cause, input ready);
  modport sink (input valid, input data_byte, input route, input last_of_frame,
                input empty_frame, input link_drop, input drop_cause, output ready);
endinterface

### src/wsfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Header, length, mask key and payload state with a one-byte update path.
// ----------------------------------------------------------------------------
module wsfd_parser
  import wsfd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 23
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   restart_i,
  input  logic [MaxPayloadW-1:0] max_payload_i,
  output logic                   res_valid_o,
  output wsfd_result_t           res_o
);

  localparam int unsigned CmpW = (LEN_BITS > MaxPayloadW) ? LEN_BITS : MaxPayloadW;

  phase_e              phase_q, phase_d;
  logic                final_q, final_d;
  logic [3:0]          opcode_q, opcode_d;
  logic [3:0]          ext_left_q, ext_left_d;
  logic [LEN_BITS-1:0] accum_q, accum_d;
  logic                over_q, over_d;
  logic [31:0]         key_q, key_d;
  logic [1:0]          pos_q, pos_d;
  logic [LEN_BITS-1:0] left_q, left_d;
  route_e              route_q, route_d;
  logic                mask_q, mask_d;

  logic                lk_valid;
  logic [LEN_BITS-1:0] lk_len;
  logic                lk_over;
  logic                lk_mask;
  logic                lk_big;
  logic                lk_ctrl_ok;
  cause_e              end_cause;
  logic [7:0]          key_byte;

  assign end_cause = !final_q ? CAUSE_NONFINAL :
                     (opcode_q == OpClose) ? CAUSE_CLOSE : CAUSE_NONE;
  assign lk_big = (CmpW'(lk_len) > CmpW'(max_payload_i));
  assign lk_ctrl_ok = (lk_len <= LEN_BITS'(CtrlMaxLen));

  always_comb begin
    unique case (pos_q)
      2'd0: key_byte = key_q[31:24];
      2'd1: key_byte = key_q[23:16];
      2'd2: key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    final_d    = final_q;
    opcode_d   = opcode_q;
    ext_left_d = ext_left_q;
    accum_d    = accum_q;
    over_d     = over_q;
    key_d      = key_q;
    pos_d      = pos_q;
    left_d     = left_q;
    route_d    = route_q;
    mask_d     = mask_q;
    lk_valid   = 1'b0;
    lk_len     = '0;
    lk_over    = 1'b0;
    lk_mask    = mask_q;
    res_valid_o = 1'b0;
    res_o = '{data_byte: 8'h00, route: RT_NONE, last_of_frame: 1'b0,
              empty_frame: 1'b0, link_drop: 1'b0, drop_cause: CAUSE_NONE};

    if (accept_i) begin
      if (restart_i) begin
        phase_d    = PH_HDR0;
        final_d    = 1'b0;
        opcode_d   = '0;
        ext_left_d = '0;
        accum_d    = '0;
        over_d     = 1'b0;
        key_d      = '0;
        pos_d      = '0;
        left_d     = '0;
        route_d    = RT_NONE;
        mask_d     = 1'b0;
      end else begin
        unique case (phase_q)
          PH_HDR0: begin
            final_d  = rx_byte_i[7];
            opcode_d = rx_byte_i[3:0];
            phase_d  = PH_HDR1;
          end
          PH_HDR1: begin
            mask_d  = rx_byte_i[7];
            lk_mask = rx_byte_i[7];
            accum_d = '0;
            over_d  = 1'b0;
            if ({1'b0, rx_byte_i[6:0]} == Len7Ext16 || {1'b0, rx_byte_i[6:0]} == Len7Ext64)
            begin
              ext_left_d = ({1'b0, rx_byte_i[6:0]} == Len7Ext16) ? ExtBytes16 : ExtBytes64;
              phase_d    = PH_EXT;
            end else begin
              lk_valid = 1'b1;
              lk_len   = LEN_BITS'(rx_byte_i[6:0]);
            end
          end
          PH_EXT: begin
            lk_over    = over_q | (accum_q[LEN_BITS-1 -: 8] != 8'h00);
            lk_len     = LEN_BITS'({accum_q, rx_byte_i});
            accum_d    = lk_len;
            over_d     = lk_over;
            ext_left_d = ext_left_q - 4'd1;
            lk_valid   = (ext_left_d == 4'd0);
          end
          PH_KEY: begin
            key_d = {key_q[23:0], rx_byte_i};
            pos_d = pos_q + 2'd1;
            if (pos_d == 2'd0) begin
              if (left_q == '0) begin
                res_valid_o         = 1'b1;
                res_o.route         = route_q;
                res_o.last_of_frame = 1'b1;
                res_o.empty_frame   = 1'b1;
                res_o.link_drop     = (end_cause != CAUSE_NONE);
                res_o.drop_cause    = end_cause;
                phase_d = (end_cause != CAUSE_NONE) ? PH_DEAD : PH_HDR0;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            pos_d  = pos_q + 2'd1;
            left_d = left_q - LEN_BITS'(1);
            res_valid_o     = 1'b1;
            res_o.route     = route_q;
            res_o.data_byte = (route_q == RT_NONE) ? 8'h00 : (rx_byte_i ^ key_byte);
            if (left_d == '0) begin
              res_o.last_of_frame = 1'b1;
              res_o.link_drop     = (end_cause != CAUSE_NONE);
              res_o.drop_cause    = end_cause;
              phase_d = (end_cause != CAUSE_NONE) ? PH_DEAD : PH_HDR0;
            end
          end
          PH_DEAD: begin
            phase_d = PH_DEAD;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase

        if (lk_valid) begin
          accum_d = lk_len;
          over_d  = lk_over;
          if (lk_over || lk_big) begin
            res_valid_o      = 1'b1;
            res_o.link_drop  = 1'b1;
            res_o.drop_cause = CAUSE_OVERSIZE;
            phase_d          = PH_DEAD;
          end else if (!lk_mask) begin
            res_valid_o      = 1'b1;
            res_o.link_drop  = 1'b1;
            res_o.drop_cause = CAUSE_UNMASKED;
            phase_d          = PH_DEAD;
          end else begin
            priority if (!final_q) begin
              route_d = RT_NONE;
            end else if (opcode_q == OpText) begin
              route_d = RT_TEXT;
            end else if (opcode_q == OpPing) begin
              route_d = lk_ctrl_ok ? RT_PONG : RT_NONE;
            end else if (opcode_q == OpClose) begin
              route_d = lk_ctrl_ok ? RT_CLOSE : RT_NONE;
            end else begin
              route_d = RT_NONE;
            end
            left_d  = lk_len;
            pos_d   = '0;
            key_d   = '0;
            phase_d = PH_KEY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      final_q    <= 1'b0;
      opcode_q   <= '0;
      ext_left_q <= '0;
      accum_q    <= '0;
      over_q     <= 1'b0;
      key_q      <= '0;
      pos_q      <= '0;
      left_q     <= '0;
      route_q    <= RT_NONE;
      mask_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      final_q    <= final_d;
      opcode_q   <= opcode_d;
      ext_left_q <= ext_left_d;
      accum_q    <= accum_d;
      over_q     <= over_d;
      key_q      <= key_d;
      pos_q      <= pos_d;
      left_q     <= left_d;
      route_q    <= route_d;
      mask_q     <= mask_d;
    end
  end

  // A dropped link stays silent until a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.link_drop) |=> (phase_q == PH_DEAD))
    else $error("link drop did not park the parser");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DEAD && accept_i && !restart_i) |-> !res_valid_o)
    else $error("result produced on a dropped link");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.empty_frame) |-> (res_o.last_of_frame && phase_q == PH_KEY))
    else $error("empty frame result outside the end of the mask key");

endmodule

### src/wsfd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer result buffer
// Output register with a skid stage so the parser keeps accepting bytes.
// ----------------------------------------------------------------------------
module wsfd_out_buf
  import wsfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  wsfd_result_t res_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output wsfd_result_t out_o
);

  logic         out_valid_q;
  logic         skid_valid_q;
  wsfd_result_t out_q;
  wsfd_result_t skid_q;
  logic         out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= res_i;
        end
      end else if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a transfer ahead of an empty output register");

endmodule

### src/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Decodes WebSocket frames one byte per cycle while input is ready; routes payload.
//
//   Port         Dir   Kind                Carries
//   in_if        in    valid/ready         rx_byte, restart
//   out_if       out   valid/ready         data_byte, route, flags, drop cause
//   cfg_we_i     in    write strobe        max_payload write
//
// One byte is taken per cycle while input is ready; each transfer updates the
// parser state and writes any result at the same edge into the output register,
// or into the skid stage while the output register is held.
// A skid stage behind the output register holds one result while the output
// is stalled, keeping input ready; input stalls only while both output stages are full.
// Reset returns the parser to the first header byte and max_payload to 4 MiB.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsfd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 23
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MaxPayloadW-1:0] cfg_wdata_i,
  wsfd_in_if.sink                in_if,
  wsfd_out_if.source             out_if
);

  logic [MaxPayloadW-1:0] max_payload_q;
  logic                   space;
  logic                   accept;
  logic                   res_valid;
  wsfd_result_t           res;
  wsfd_result_t           out_res;

  assign in_if.ready = space;
  assign accept      = in_if.valid && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  wsfd_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (in_if.rx_byte),
    .restart_i    (in_if.restart),
    .max_payload_i(max_payload_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsfd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .res_i      (res),
    .space_o    (space),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_o      (out_res)
  );

  assign out_if.data_byte     = out_res.data_byte;
  assign out_if.route         = out_res.route;
  assign out_if.last_of_frame = out_res.last_of_frame;
  assign out_if.empty_frame   = out_res.empty_frame;
  assign out_if.link_drop     = out_res.link_drop;
  assign out_if.drop_cause    = out_res.drop_cause;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends directed and random WebSocket byte streams with random gaps and output
// stalls, and checks each transfer against an internal decoder or a directed result.
// ----------------------------------------------------------------------------
module tb_top;
  import wsfd_pkg::*;

  typedef enum int {CHK_MODEL, CHK_RESULT, CHK_SILENT} chk_e;
  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_enc_e;

  typedef struct {
    logic [7:0]   b;
    logic         rst;
    chk_e         chk;
    wsfd_result_t want;
  } stim_t;

  typedef struct {
    bit                     is_cfg;
    logic [MaxPayloadW-1:0] cfg_val;
    stim_t                  item;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [MaxPayloadW-1:0] cfg_wdata_i;

  wsfd_in_if  in_ch ();
  wsfd_out_if out_ch ();

  websocket_frame_deframer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder state kept alongside the block.
  logic [MaxPayloadW-1:0] max_payload;
  phase_e                 dfr_phase;
  logic                   dfr_fin;
  logic [3:0]             dfr_opcode;
  logic [3:0]             dfr_ext_left;
  logic [MaxPayloadW-1:0] dfr_len;
  logic                   dfr_len_over;
  logic [31:0]            dfr_key;
  logic [1:0]             dfr_key_pos;
  logic [MaxPayloadW-1:0] dfr_left;
  route_e                 dfr_route;
  logic                   dfr_masked;

  wsfd_result_t pending_results[$];
  stim_t        stim_q[$];
  dir_row_t     dir_rows[$];
  bit           idle_on = 1'b1;
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           results_seen = 0;
  int           drops_seen = 0;
  int           settings_used = 0;

  function automatic wsfd_result_t make_result(logic [7:0] d, route_e r, logic last,
                                               logic empty, cause_e c);
    wsfd_result_t res;
    res.data_byte     = d;
    res.route         = r;
    res.last_of_frame = last;
    res.empty_frame   = empty;
    res.link_drop     = (c != CAUSE_NONE);
    res.drop_cause    = c;
    return res;
  endfunction

  function automatic void clear_parser();
    dfr_phase    = PH_HDR0;
    dfr_fin      = 1'b0;
    dfr_opcode   = '0;
    dfr_ext_left = '0;
    dfr_len      = '0;
    dfr_len_over = 1'b0;
    dfr_key      = '0;
    dfr_key_pos  = '0;
    dfr_left     = '0;
    dfr_route    = RT_NONE;
    dfr_masked   = 1'b0;
  endfunction

  function automatic cause_e frame_end_cause();
    cause_e c;
    c = CAUSE_NONE;
    if (!dfr_fin) begin
      c = CAUSE_NONFINAL;
    end else if (dfr_opcode == OpClose) begin
      c = CAUSE_CLOSE;
    end
    if (c != CAUSE_NONE) begin
      dfr_phase = PH_DEAD;
    end else begin
      dfr_phase = PH_HDR0;
    end
    return c;
  endfunction

  function automatic bit length_known(output wsfd_result_t res);
    res = '0;
    if (dfr_len_over || dfr_len > max_payload) begin
      res = make_result(8'h00, RT_NONE, 1'b0, 1'b0, CAUSE_OVERSIZE);
      dfr_phase = PH_DEAD;
      return 1'b1;
    end
    if (!dfr_masked) begin
      res = make_result(8'h00, RT_NONE, 1'b0, 1'b0, CAUSE_UNMASKED);
      dfr_phase = PH_DEAD;
      return 1'b1;
    end
    dfr_route = RT_NONE;
    if (dfr_fin && dfr_opcode == OpText) begin
      dfr_route = RT_TEXT;
    end else if (dfr_fin && dfr_opcode == OpPing &&
                 dfr_len <= MaxPayloadW'(CtrlMaxLen)) begin
      dfr_route = RT_PONG;
    end else if (dfr_fin && dfr_opcode == OpClose &&
                 dfr_len <= MaxPayloadW'(CtrlMaxLen)) begin
      dfr_route = RT_CLOSE;
    end
    dfr_left    = dfr_len;
    dfr_key_pos = '0;
    dfr_key     = '0;
    dfr_phase   = PH_KEY;
    return 1'b0;
  endfunction

  function automatic bit deframe_step(input logic [7:0] b, input logic rst,
                                      output wsfd_result_t res);
    logic [6:0] len7;
    logic [7:0] data;
    cause_e     c;
    res = '0;
    if (rst) begin
      clear_parser();
      return 1'b0;
    end
    case (dfr_phase)
      PH_HDR0: begin
        dfr_fin    = b[7];
        dfr_opcode = b[3:0];
        dfr_phase  = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        len7         = b[6:0];
        dfr_masked   = b[7];
        dfr_len      = '0;
        dfr_len_over = 1'b0;
        if (len7 == Len7Ext16[6:0] || len7 == Len7Ext64[6:0]) begin
          dfr_ext_left = (len7 == Len7Ext16[6:0]) ? ExtBytes16 : ExtBytes64;
          dfr_phase    = PH_EXT;
          return 1'b0;
        end
        dfr_len = MaxPayloadW'(len7);
        return length_known(res);
      end
      PH_EXT: begin
        if (dfr_len[MaxPayloadW-1:MaxPayloadW-8] != '0) begin
          dfr_len_over = 1'b1;
        end
        dfr_len      = {dfr_len[MaxPayloadW-9:0], b};
        dfr_ext_left = dfr_ext_left - 4'd1;
        if (dfr_ext_left != '0) begin
          return 1'b0;
        end
        return length_known(res);
      end
      PH_KEY: begin
        dfr_key     = {dfr_key[23:0], b};
        dfr_key_pos = dfr_key_pos + 2'd1;
        if (dfr_key_pos != '0) begin
          return 1'b0;
        end
        if (dfr_left == '0) begin
          c   = frame_end_cause();
          res = make_result(8'h00, dfr_route, 1'b1, 1'b1, c);
          return 1'b1;
        end
        dfr_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        data = b ^ dfr_key[8*(3-dfr_key_pos) +: 8];
        if (dfr_route == RT_NONE) begin
          data = 8'h00;
        end
        dfr_key_pos = dfr_key_pos + 2'd1;
        dfr_left    = dfr_left - MaxPayloadW'(1);
        c           = CAUSE_NONE;
        if (dfr_left == '0) begin
          c = frame_end_cause();
        end
        res = make_result(data, dfr_route, dfr_left == '0, 1'b0, c);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_t model_item(logic [7:0] b, logic rst);
    stim_t s;
    s.b    = b;
    s.rst  = rst;
    s.chk  = CHK_MODEL;
    s.want = '0;
    return s;
  endfunction

  function automatic void dir_byte(logic [7:0] b, logic rst, chk_e chk, wsfd_result_t want);
    dir_row_t row;
    row.is_cfg    = 1'b0;
    row.cfg_val   = '0;
    row.item      = model_item(b, rst);
    row.item.chk  = chk;
    row.item.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_cfg(logic [MaxPayloadW-1:0] v);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    row.item    = model_item(8'h00, 1'b0);
    dir_rows.push_back(row);
  endfunction

  // Appends one random frame; returns the number of frame bytes queued.
  function automatic int queue_frame(int unsigned mp);
    logic [3:0]  opc;
    logic        fin;
    logic        masked;
    logic [63:0] len;
    logic [6:0]  len7;
    len_enc_e    enc;
    logic [7:0]  frame_bytes[$];
    int unsigned sel;
    int unsigned n_kept;
    bit          dies;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      opc = OpText;
    end else if (sel < 58) begin
      opc = OpPing;
    end else if (sel < 68) begin
      opc = OpClose;
    end else begin
      opc = 4'($urandom_range(0, 15));
    end
    fin    = ($urandom_range(0, 9) != 0);
    masked = ($urandom_range(0, 19) != 0);
    sel    = $urandom_range(0, 99);
    if (sel < 55) begin
      len = 64'($urandom_range(0, 24));
    end else if (sel < 70) begin
      len = 64'($urandom_range(120, 130));
    end else if (sel < 80) begin
      len = (mp <= 300) ? 64'(mp) + 64'($urandom_range(0, 1)) :
                          64'($urandom_range(0, 3));
    end else if (sel < 92) begin
      len = 64'(mp) + 64'(1) + 64'($urandom_range(0, 70000));
    end else begin
      len = {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
    end
    if (len <= 125) begin
      enc = len_enc_e'($urandom_range(0, 2));
    end else if (len <= 65535) begin
      enc = len_enc_e'($urandom_range(1, 2));
    end else begin
      enc = LEN_EXT64;
    end
    case (enc)
      LEN_SHORT: len7 = len[6:0];
      LEN_EXT16: len7 = Len7Ext16[6:0];
      default:   len7 = Len7Ext64[6:0];
    endcase
    frame_bytes.push_back({fin, 3'($urandom), opc});
    frame_bytes.push_back({masked, len7});
    if (enc == LEN_EXT16) begin
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
    end else if (enc == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) begin
        frame_bytes.push_back(len[8*i +: 8]);
      end
    end
    dies = !masked || len > 64'(mp) || !fin || opc == OpClose;
    if (masked && len <= 64'(mp)) begin
      for (int i = 0; i < 4 + int'(len); i++) begin
        frame_bytes.push_back(8'($urandom));
      end
    end
    n_kept = frame_bytes.size();
    if (frame_bytes.size() > 1 && $urandom_range(0, 19) == 0) begin
      n_kept = $urandom_range(1, frame_bytes.size() - 1);
      dies   = 1'b1;
    end
    for (int i = 0; i < int'(n_kept); i++) begin
      stim_q.push_back(model_item(frame_bytes[i], 1'b0));
    end
    if (dies) begin
      repeat ($urandom_range(0, 2)) stim_q.push_back(model_item(8'($urandom), 1'b0));
      stim_q.push_back(model_item(8'($urandom), 1'b1));
    end
    return int'(n_kept);
  endfunction

  task automatic send_stream();
    stim_t        cur;
    wsfd_result_t res;
    bit           has_res;
    while (stim_q.size() > 0) begin
      if (idle_on && $urandom_range(0, 9) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      cur = stim_q.pop_front();
      in_ch.valid   <= 1'b1;
      in_ch.rx_byte <= cur.b;
      in_ch.restart <= cur.rst;
      do @(posedge clk_i); while (!in_ch.ready);
      bytes_sent++;
      has_res = deframe_step(cur.b, cur.rst, res);
      case (cur.chk)
        CHK_MODEL:  if (has_res) pending_results.push_back(res);
        CHK_RESULT: pending_results.push_back(cur.want);
        default:    ;
      endcase
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max_payload(logic [MaxPayloadW-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_payload = v;
    settings_used++;
  endtask

  task automatic report_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : check_output
    wsfd_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none, got data %0h route %0d cause %0d",
                 $time, out_ch.data_byte, out_ch.route, out_ch.drop_cause);
      end else begin
        want = pending_results.pop_front();
        if (want.link_drop) drops_seen++;
        report_field("data_byte", want.data_byte, out_ch.data_byte);
        report_field("route", 8'(want.route), 8'(out_ch.route));
        report_field("last_of_frame", 8'(want.last_of_frame), 8'(out_ch.last_of_frame));
        report_field("empty_frame", 8'(want.empty_frame), 8'(out_ch.empty_frame));
        report_field("link_drop", 8'(want.link_drop), 8'(out_ch.link_drop));
        report_field("drop_cause", 8'(want.drop_cause), 8'(out_ch.drop_cause));
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("websocket_frame_deframer: mismatch");
    $finish;
  end

  initial begin
    int unsigned max_settings[7];
    int          phase_bytes;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    in_ch.restart <= 1'b0;
    max_payload = MaxPayloadReset;
    clear_parser();

    // Text frame, empty ping, unmasked frame, dropped link and restart, then
    // an oversize frame and an empty close with max_payload at zero.
    dir_byte(8'h81, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h82, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h11, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h22, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h33, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h44, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h61, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h62, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h89, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h80, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h00, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h00, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h00, 1'b0, CHK_MODEL, '0);
    dir_byte(8'hFF, 1'b0, CHK_RESULT, make_result(8'h00, RT_PONG, 1'b1, 1'b1, CAUSE_NONE));
    dir_byte(8'h81, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h05, 1'b0, CHK_RESULT,
             make_result(8'h00, RT_NONE, 1'b0, 1'b0, CAUSE_UNMASKED));
    dir_byte(8'hFF, 1'b0, CHK_SILENT, '0);
    dir_byte(8'hFF, 1'b1, CHK_SILENT, '0);
    dir_cfg('0);
    dir_byte(8'h81, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h81, 1'b0, CHK_RESULT,
             make_result(8'h00, RT_NONE, 1'b0, 1'b0, CAUSE_OVERSIZE));
    dir_byte(8'h00, 1'b1, CHK_SILENT, '0);
    dir_byte(8'h88, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h80, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h5A, 1'b0, CHK_MODEL, '0);
    dir_byte(8'hA5, 1'b0, CHK_MODEL, '0);
    dir_byte(8'h0F, 1'b0, CHK_MODEL, '0);
    dir_byte(8'hF0, 1'b0, CHK_RESULT, make_result(8'h00, RT_CLOSE, 1'b1, 1'b1, CAUSE_CLOSE));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        send_stream();
        write_max_payload(dir_rows[i].cfg_val);
      end else begin
        stim_q.push_back(dir_rows[i].item);
      end
    end
    send_stream();

    max_settings    = '{32'h7F_FFFF, 0, 125, 126, 20, 32'h40_0000, 0};
    max_settings[6] = $urandom_range(1, 300);
    foreach (max_settings[i]) begin
      if (i == 6) idle_on = 1'b0;
      write_max_payload(MaxPayloadW'(max_settings[i]));
      stim_q.push_back(model_item(8'($urandom), 1'b1));
      phase_bytes = 0;
      while (phase_bytes < 100) phase_bytes += queue_frame(max_settings[i]);
      send_stream();
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes under %0d max_payload settings.", bytes_sent, settings_used);
    $display("Checked %0d result transfers, %0d of them link drops.", results_seen, drops_seen);
    if (mismatches == 0) begin
      $display("websocket_frame_deframer: match");
    end else begin
      $display("websocket_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule
